[rtl/core/scc_pkg.sv]
package scc_pkg;

   // Directory geometry
   localparam int ENTRIES      = 64;
   localparam int IDX_W        = $clog2(ENTRIES);
   localparam int SECTOR_BYTES = 512;
   localparam int MAX_RESULTS  = 64;
   localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

   // Field widths
   localparam int CMD_W    = 2;
   localparam int SECTOR_W = 32;
   localparam int ADDR_W   = 32;
   localparam int HOFF_W   = 31;
   localparam int SOFF_W   = 9;
   localparam int LEN_W    = 10;
   localparam int ACT_W    = 3;
   localparam int ENT_W    = 6;

   // Stream payload widths (packed fields, padded to whole bytes)
   localparam int REQ_BITS   = SECTOR_W + ADDR_W + HOFF_W + SOFF_W + LEN_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = ENT_W + SECTOR_W + SOFF_W + ADDR_W + LEN_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE_BACK = 3'd0,
      ACT_FILL       = 3'd1,
      ACT_TO_HOST    = 3'd2,
      ACT_FROM_HOST  = 3'd3,
      ACT_FLUSH_DONE = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP,
      ST_WB_EMIT,
      ST_FILL,
      ST_COPY,
      ST_FL_SCAN,
      ST_FL_EMIT,
      ST_FL_DONE
   } state_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [SECTOR_W-1:0] sector;
      logic [ADDR_W-1:0]   host_base;
      logic [HOFF_W-1:0]   host_offset;
      logic [SOFF_W-1:0]   sector_offset;
      logic [LEN_W-1:0]    chunk_length;
   } req_type;

   typedef struct packed {
      action_type          action;
      logic [ENT_W-1:0]    entry_index;
      logic [SECTOR_W-1:0] disk_sector;
      logic [SOFF_W-1:0]   cache_byte_offset;
      logic [ADDR_W-1:0]   host_address;
      logic [LEN_W-1:0]    copy_length;
      logic                was_hit;
      logic                last;
   } rsp_type;

endpackage

[rtl/core/scc_ram.sv]
module scc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/scc_seq.sv]
module scc_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  scc_pkg::req_type req_data,
   output logic             res_valid,
   input  logic             res_ready,
   output scc_pkg::rsp_type res_data
);
   import scc_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   cmp_ff, cmp_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   hand_ff, hand_in;
   logic [IDX_W-1:0]   ent_ff, ent_in;
   logic               hit_ff, hit_in;
   logic [CNT_W-1:0]   wbcnt_ff, wbcnt_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] dirty_ff, dirty_in;
   logic [ENTRIES-1:0] ref_ff, ref_in;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [SECTOR_W-1:0] tag_rd;
   logic [LEN_W:0]      room;
   logic [LEN_W-1:0]    copy_len;
   logic                wb_last;

   // Tag store: one entry read per cycle by the scan/sweep sequencer
   scc_ram #(
      .WIDTH (SECTOR_W),
      .DEPTH (ENTRIES)
   ) u_tags (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ent_ff),
      .wr_data (req_ff.sector),
      .rd_addr (ram_rd_addr),
      .rd_data (tag_rd)
   );

   assign ram_rd_addr = (state_ff == ST_SWEEP || state_ff == ST_WB_EMIT) ? hand_ff : ptr_ff;

   // Copy length clipped to the end of the sector
   assign room = (LEN_W+1)'(SECTOR_BYTES) - (LEN_W+1)'(req_ff.sector_offset);
   always_comb begin
      if ((LEN_W+1)'(req_ff.sector_offset) >= (LEN_W+1)'(SECTOR_BYTES)) begin
         copy_len = '0;
      end else if ((LEN_W+1)'(req_ff.chunk_length) > room) begin
         copy_len = room[LEN_W-1:0];
      end else begin
         copy_len = req_ff.chunk_length;
      end
   end

   // Write-back that fills the result budget closes the flush
   assign wb_last = (wbcnt_ff == CNT_W'(MAX_RESULTS - 1));

   // State and directory registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         hand_ff  <= '0;
         valid_ff <= '0;
         dirty_ff <= '0;
         ref_ff   <= '0;
         wbcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         hand_ff  <= hand_in;
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         ref_ff   <= ref_in;
         wbcnt_ff <= wbcnt_in;
      end
      req_ff <= req_in;
      ptr_ff <= ptr_in;
      cmp_ff <= cmp_in;
      ent_ff <= ent_in;
      hit_ff <= hit_in;
   end

   // Sequencer: next state and results
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      ptr_in    = ptr_ff;
      cmp_in    = cmp_ff;
      pend_in   = pend_ff;
      hand_in   = hand_ff;
      ent_in    = ent_ff;
      hit_in    = hit_ff;
      wbcnt_in  = wbcnt_ff;
      valid_in  = valid_ff;
      dirty_in  = dirty_ff;
      ref_in    = ref_ff;
      ram_we    = 1'b0;
      req_ready = 1'b0;
      res_valid = 1'b0;
      res_data  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               ptr_in   = '0;
               pend_in  = 1'b0;
               wbcnt_in = '0;
               unique case (req_data.cmd)
                  CMD_READ, CMD_WRITE: state_in = ST_LOOKUP;
                  CMD_FLUSH:           state_in = ST_FL_SCAN;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end

         // Read tag at ptr, compare the one read last cycle
         ST_LOOKUP: begin
            ptr_in  = ptr_ff + 1'b1;
            cmp_in  = ptr_ff;
            pend_in = 1'b1;
            if (pend_ff && valid_ff[cmp_ff] && tag_rd == req_ff.sector) begin
               ent_in   = cmp_ff;
               hit_in   = 1'b1;
               state_in = ST_COPY;
            end else if (pend_ff && cmp_ff == LAST_IDX) begin
               hit_in   = 1'b0;
               state_in = ST_SWEEP;
            end
         end

         // Clock hand: clear reference bits until a victim turns up
         ST_SWEEP: begin
            if (ref_ff[hand_ff]) begin
               ref_in[hand_ff] = 1'b0;
               hand_in = (hand_ff == LAST_IDX) ? '0 : hand_ff + 1'b1;
            end else begin
               ent_in   = hand_ff;
               state_in = (valid_ff[hand_ff] && dirty_ff[hand_ff]) ? ST_WB_EMIT : ST_FILL;
            end
         end

         ST_WB_EMIT: begin
            res_valid            = 1'b1;
            res_data.action      = ACT_WRITE_BACK;
            res_data.entry_index = ENT_W'(ent_ff);
            res_data.disk_sector = tag_rd;
            if (res_ready) begin
               state_in = ST_FILL;
            end
         end

         ST_FILL: begin
            res_valid            = 1'b1;
            res_data.action      = ACT_FILL;
            res_data.entry_index = ENT_W'(ent_ff);
            res_data.disk_sector = req_ff.sector;
            if (res_ready) begin
               ram_we           = 1'b1;
               valid_in[ent_ff] = 1'b1;
               dirty_in[ent_ff] = 1'b0;
               state_in         = ST_COPY;
            end
         end

         ST_COPY: begin
            res_valid                  = 1'b1;
            res_data.action            = (req_ff.cmd == CMD_READ) ? ACT_TO_HOST : ACT_FROM_HOST;
            res_data.entry_index       = ENT_W'(ent_ff);
            res_data.cache_byte_offset = req_ff.sector_offset;
            res_data.host_address      = req_ff.host_base + ADDR_W'(req_ff.host_offset);
            res_data.copy_length       = copy_len;
            res_data.was_hit           = hit_ff;
            res_data.last              = 1'b1;
            if (res_ready) begin
               ref_in[ent_ff] = 1'b1;
               if (req_ff.cmd == CMD_WRITE) begin
                  dirty_in[ent_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         // Flush: walk entries in index order
         ST_FL_SCAN: begin
            if (dirty_ff[ptr_ff]) begin
               state_in = ST_FL_EMIT;
            end else if (ptr_ff == LAST_IDX) begin
               state_in = ST_FL_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         ST_FL_EMIT: begin
            res_valid            = 1'b1;
            res_data.action      = ACT_WRITE_BACK;
            res_data.entry_index = ENT_W'(ptr_ff);
            res_data.disk_sector = tag_rd;
            res_data.last        = wb_last;
            if (res_ready) begin
               dirty_in[ptr_ff] = 1'b0;
               wbcnt_in         = wbcnt_ff + 1'b1;
               if (wb_last) begin
                  state_in = ST_IDLE;
               end else if (ptr_ff == LAST_IDX) begin
                  state_in = ST_FL_DONE;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = ST_FL_SCAN;
               end
            end
         end

         ST_FL_DONE: begin
            res_valid       = 1'b1;
            res_data.action = ACT_FLUSH_DONE;
            res_data.last   = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/sector_cache_clock_controller.sv]
// Sector cache directory with clock replacement, write-back, fully associative.
// Request stream (req_*): one transaction per read, write or flush command;
// req_tuser carries the command. Result stream (rsp_*): one or more result
// transactions per request, rsp_tuser carries the action, rsp_tlast marks the
// final result of a request. An unknown command is dropped without results.
// Once the request is taken, the tag lookup reads one entry per cycle from the
// tag RAM. A hit then issues its copy; a miss runs the clock hand one entry
// per cycle, then write back (if dirty), fill and copy. A flush walks all
// entries one per cycle, pausing at each dirty entry to emit its write-back.
// One request is in work at a time: req_tready is high only between
// requests.
// Results pass through an output register; when the receiver holds
// rsp_tready low the sequencer waits with its next result and nothing is lost.
// Reset clears all valid, dirty and reference bits and the hand; tag contents
// are not cleared since only valid entries are ever compared.
module sector_cache_clock_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // sector, host_base, host_offset, sector_offset, chunk_length, zero pad
   input  logic [scc_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [scc_pkg::CMD_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // entry_index, disk_sector, cache_byte_offset, host_address, copy_length,
   // was_hit, zero pad
   output logic [scc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // action
   output logic [scc_pkg::ACT_W-1:0]      rsp_tuser,
   output logic                           rsp_tlast
);
   import scc_pkg::*;

   req_type req;
   rsp_type res;
   logic    res_valid;
   logic    res_ready;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // Unpack request transaction
   assign req.cmd           = cmd_type'(req_tuser);
   assign req.sector        = req_tdata[31:0];
   assign req.host_base     = req_tdata[63:32];
   assign req.host_offset   = req_tdata[94:64];
   assign req.sector_offset = req_tdata[103:95];
   assign req.chunk_length  = req_tdata[113:104];

   scc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_data  (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res)
   );

   // Output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   // Pack result transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_BITS)'(0),
                        rsp_ff.was_hit,
                        rsp_ff.copy_length,
                        rsp_ff.host_address,
                        rsp_ff.cache_byte_offset,
                        rsp_ff.disk_sector,
                        rsp_ff.entry_index};

endmodule
